[src/fba_pkg.sv]
// ============================================================================
// fba_pkg
// Shared types and codes of the file block allocator: item modes, result
// status codes, controller states and the controller/datapath interface.
// ============================================================================
package fba_pkg;

    // Field widths fixed by the item and result formats
    localparam int MODE_W   = 2;
    localparam int SIZE_W   = 10;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_O_W = 4;
    localparam int BLK_O_W  = 4;
    localparam int SIZE_MAX = 1023;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CR_CHECK,
        S_CR_SLOT,
        S_CR_ALLOC,
        S_FID_CHECK,
        S_CAP_CNT,
        S_RD_CHAIN,
        S_USE_CHAIN,
        S_DEL_DONE
    } fba_state_t;

    // Kind of result loaded into the output register
    typedef enum logic [2:0] {
        OUT_ALLOC,
        OUT_LIST,
        OUT_ERR_SPACE,
        OUT_ERR_SLOT,
        OUT_ERR_USE,
        OUT_DEL
    } fba_out_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic         in_ready;
        logic         init_scan;
        logic         next_slot;
        logic         init_walk;
        logic         alloc;
        logic         skip_block;
        logic         rd_cnt;
        logic         cap_cnt;
        logic         rd_chain;
        logic         free_blk;
        logic         clear_slot;
        logic         emit;
        fba_out_sel_t out_sel;
    } fba_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              space_ok;
        logic              slot_free;
        logic              slot_scan_end;
        logic              block_free;
        logic              alloc_last;
        logic              fid_ok;
        logic              walk_end;
    } fba_sts_t;

endpackage

[src/fba_ram.sv]
// ============================================================================
// fba_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ============================================================================
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/fba_ctrl.sv]
// ============================================================================
// fba_ctrl
// Controller of the file block allocator: sequences slot search, block
// allocation walk, chain read walk and result emission.
// ============================================================================
module fba_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [fba_pkg::MODE_W-1:0] in_mode,
    input  fba_pkg::fba_sts_t         sts,
    output fba_pkg::fba_cmd_t         cmd
);
    import fba_pkg::*;

    fba_state_t state_reg;
    fba_state_t state_next;
    logic       in_fire;

    assign in_fire = in_valid && (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_mode == MODE_CREATE)
                    begin
                        state_next = S_CR_CHECK;
                    end
                    else if (in_mode == MODE_DELETE || in_mode == MODE_LIST)
                    begin
                        state_next = S_FID_CHECK;
                    end
                end
            end
            S_CR_CHECK:
            begin
                if (sts.space_ok)
                begin
                    state_next = S_CR_SLOT;
                end
                else if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CR_SLOT:
            begin
                if (sts.slot_free)
                begin
                    state_next = S_CR_ALLOC;
                end
                else if (sts.slot_scan_end && sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CR_ALLOC:
            begin
                if (sts.block_free && sts.out_free && sts.alloc_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FID_CHECK:
            begin
                if (sts.fid_ok)
                begin
                    state_next = S_CAP_CNT;
                end
                else if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CAP_CNT:
            begin
                state_next = S_RD_CHAIN;
            end
            S_RD_CHAIN:
            begin
                state_next = S_USE_CHAIN;
            end
            S_USE_CHAIN:
            begin
                if (sts.mode == MODE_DELETE)
                begin
                    state_next = sts.walk_end ? S_DEL_DONE : S_RD_CHAIN;
                end
                else if (sts.out_free)
                begin
                    state_next = sts.walk_end ? S_IDLE : S_RD_CHAIN;
                end
            end
            S_DEL_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = OUT_ALLOC;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.init_scan = 1'b1;
            end
            S_CR_CHECK:
            begin
                if (!sts.space_ok && sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OUT_ERR_SPACE;
                end
            end
            S_CR_SLOT:
            begin
                if (sts.slot_free)
                begin
                    cmd.init_walk = 1'b1;
                end
                else if (sts.slot_scan_end)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.out_sel = OUT_ERR_SLOT;
                    end
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                end
            end
            S_CR_ALLOC:
            begin
                if (!sts.block_free)
                begin
                    cmd.skip_block = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.alloc   = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OUT_ALLOC;
                end
            end
            S_FID_CHECK:
            begin
                if (sts.fid_ok)
                begin
                    cmd.rd_cnt = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OUT_ERR_USE;
                end
            end
            S_CAP_CNT:
            begin
                cmd.cap_cnt = 1'b1;
            end
            S_RD_CHAIN:
            begin
                cmd.rd_chain = 1'b1;
            end
            S_USE_CHAIN:
            begin
                if (sts.mode == MODE_DELETE)
                begin
                    cmd.free_blk = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OUT_LIST;
                end
            end
            S_DEL_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.clear_slot = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.out_sel    = OUT_DEL;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/fba_datapath.sv]
// ============================================================================
// fba_datapath
// Datapath of the file block allocator: item register, block and slot
// bitmaps, free block count, walk counters, chain and count memories and
// the output register.
// ============================================================================
module fba_datapath #(
    parameter int NUM_BLOCKS  = 16,
    parameter int FILE_SLOTS  = 16,
    parameter int BLOCK_BYTES = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fba_pkg::MODE_W-1:0]    in_mode,
    input  logic [fba_pkg::SIZE_W-1:0]    in_file_size,
    input  logic [fba_pkg::ID_W-1:0]      in_file_id,
    input  fba_pkg::fba_cmd_t             cmd,
    output fba_pkg::fba_sts_t             sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [fba_pkg::STATUS_W-1:0]  out_status,
    output logic [fba_pkg::SLOT_O_W-1:0]  out_slot,
    output logic [fba_pkg::BLK_O_W-1:0]   out_block_index,
    output logic                          out_last
);
    import fba_pkg::*;

    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int SLOT_W  = $clog2(FILE_SLOTS);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W  = CNT_W + BB_W;
    localparam int CMP_W   = (PROD_W > SIZE_W) ? PROD_W : SIZE_W;
    localparam int ACC_W   = $clog2(SIZE_MAX + BLOCK_BYTES + 1);
    localparam int CH_DEPTH = FILE_SLOTS * NUM_BLOCKS;
    localparam int ADDR_W  = $clog2(CH_DEPTH);

    // Item register
    logic [MODE_W-1:0]     mode_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ID_W-1:0]       fid_reg;

    // Allocation state
    logic [NUM_BLOCKS-1:0] block_used_reg;
    logic [FILE_SLOTS-1:0] slot_used_reg;
    logic [CNT_W-1:0]      free_count_reg;

    // Walk counters
    logic [SLOT_W-1:0]     slot_reg;
    logic [IDX_W-1:0]      blk_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [CNT_W-1:0]      j_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_O_W-1:0]   out_slot_reg;
    logic [BLK_O_W-1:0]    out_blk_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    logic [SLOT_W-1:0]     fid_idx;
    logic                  fid_in_range;
    logic [CMP_W-1:0]      space_bytes;
    logic [ACC_W-1:0]      acc_step;
    logic [CNT_W-1:0]      n_inc;
    logic [CNT_W-1:0]      j_inc;
    logic [ADDR_W-1:0]     ch_wr_addr;
    logic [ADDR_W-1:0]     ch_rd_addr;
    logic [IDX_W-1:0]      ch_rd_data;
    logic [CNT_W-1:0]      cnt_rd_data;
    logic                  cnt_wr_en;
    logic                  free_hit;

    assign in_fire      = in_valid && cmd.in_ready;
    assign fid_idx      = SLOT_W'(fid_reg);
    assign fid_in_range = (int'(fid_reg) < FILE_SLOTS);
    assign space_bytes  = CMP_W'(free_count_reg) * CMP_W'(BLOCK_BYTES);
    assign acc_step     = acc_reg + ACC_W'(BLOCK_BYTES);
    assign n_inc        = n_reg + CNT_W'(1);
    assign j_inc        = j_reg + CNT_W'(1);
    assign free_hit     = block_used_reg[ch_rd_data];
    assign cnt_wr_en    = cmd.alloc && sts.alloc_last;

    // Chain addresses: slot row times blocks per row plus position
    assign ch_wr_addr = ADDR_W'(slot_reg) * ADDR_W'(NUM_BLOCKS) + ADDR_W'(n_reg);
    assign ch_rd_addr = ADDR_W'(fid_idx) * ADDR_W'(NUM_BLOCKS)
                        + ADDR_W'(j_reg[IDX_W-1:0]);

    // Status toward the controller
    always_comb
    begin
        sts               = '0;
        sts.mode          = mode_reg;
        sts.out_free      = !out_valid_reg || out_ready;
        sts.space_ok      = (free_count_reg != '0)
                            && (CMP_W'(size_reg) <= space_bytes);
        sts.slot_free     = !slot_used_reg[slot_reg];
        sts.slot_scan_end = (int'(slot_reg) == FILE_SLOTS - 1);
        sts.block_free    = !block_used_reg[blk_reg];
        sts.alloc_last    = (acc_step >= ACC_W'(size_reg));
        sts.fid_ok        = fid_in_range && slot_used_reg[fid_idx];
        sts.walk_end      = (j_inc == cnt_reg);
    end

    // Latch accepted item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= in_mode;
            size_reg <= in_file_size;
            fid_reg  <= in_file_id;
        end
    end

    // Bitmaps and free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_used_reg <= '0;
            slot_used_reg  <= '0;
            free_count_reg <= CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            if (cmd.alloc)
            begin
                block_used_reg[blk_reg] <= 1'b1;
                free_count_reg          <= free_count_reg - CNT_W'(1);
                if (sts.alloc_last)
                begin
                    slot_used_reg[slot_reg] <= 1'b1;
                end
            end
            else if (cmd.free_blk && free_hit)
            begin
                block_used_reg[ch_rd_data] <= 1'b0;
                free_count_reg             <= free_count_reg + CNT_W'(1);
            end
            if (cmd.clear_slot)
            begin
                slot_used_reg[fid_idx] <= 1'b0;
            end
        end
    end

    // Walk counters
    always_ff @(posedge clk)
    begin
        if (cmd.init_scan)
        begin
            slot_reg <= '0;
        end
        else if (cmd.next_slot)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end

        if (cmd.init_walk)
        begin
            blk_reg <= '0;
            n_reg   <= '0;
            acc_reg <= '0;
        end
        else if (cmd.alloc)
        begin
            blk_reg <= blk_reg + IDX_W'(1);
            n_reg   <= n_inc;
            acc_reg <= acc_step;
        end
        else if (cmd.skip_block)
        begin
            blk_reg <= blk_reg + IDX_W'(1);
        end

        if (cmd.cap_cnt)
        begin
            cnt_reg <= cnt_rd_data;
            j_reg   <= '0;
        end
        else if (cmd.free_blk || (cmd.emit && cmd.out_sel == OUT_LIST))
        begin
            j_reg <= j_inc;
        end
    end

    // Block chain of every slot
    fba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CH_DEPTH)
    ) u_chain_ram (
        .clk     (clk),
        .wr_en   (cmd.alloc),
        .wr_addr (ch_wr_addr),
        .wr_data (blk_reg),
        .rd_en   (cmd.rd_chain),
        .rd_addr (ch_rd_addr),
        .rd_data (ch_rd_data)
    );

    // Chain length of every slot
    fba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (FILE_SLOTS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (slot_reg),
        .wr_data (n_inc),
        .rd_en   (cmd.rd_cnt),
        .rd_addr (fid_idx),
        .rd_data (cnt_rd_data)
    );

    // Output valid: set on load, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.out_sel)
                OUT_ALLOC:
                begin
                    out_status_reg <= ST_OK;
                    out_slot_reg   <= SLOT_O_W'(slot_reg);
                    out_blk_reg    <= BLK_O_W'(blk_reg);
                    out_last_reg   <= sts.alloc_last;
                end
                OUT_LIST:
                begin
                    out_status_reg <= ST_OK;
                    out_slot_reg   <= fid_reg;
                    out_blk_reg    <= BLK_O_W'(ch_rd_data);
                    out_last_reg   <= sts.walk_end;
                end
                OUT_ERR_SPACE:
                begin
                    out_status_reg <= ST_NO_SPACE;
                    out_slot_reg   <= '0;
                    out_blk_reg    <= '0;
                    out_last_reg   <= 1'b1;
                end
                OUT_ERR_SLOT:
                begin
                    out_status_reg <= ST_NO_SLOT;
                    out_slot_reg   <= '0;
                    out_blk_reg    <= '0;
                    out_last_reg   <= 1'b1;
                end
                OUT_ERR_USE:
                begin
                    out_status_reg <= ST_NOT_IN_USE;
                    out_slot_reg   <= fid_reg;
                    out_blk_reg    <= '0;
                    out_last_reg   <= 1'b1;
                end
                OUT_DEL:
                begin
                    out_status_reg <= ST_OK;
                    out_slot_reg   <= fid_reg;
                    out_blk_reg    <= '0;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                    out_status_reg <= ST_OK;
                    out_slot_reg   <= '0;
                    out_blk_reg    <= '0;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_slot        = out_slot_reg;
    assign out_block_index = out_blk_reg;
    assign out_last        = out_last_reg;

endmodule

[src/file_block_allocator.sv]
// ============================================================================
// file_block_allocator
// File allocation table over a pool of fixed-size blocks with first-fit
// block allocation, per-slot chains, delete and list.
// ============================================================================
// Usage:
//   Items arrive on the s_axis channel (mode, file_size, file_id) and are
//   taken one at a time; s_axis_tready is high only while the block is idle.
//   Results leave on the m_axis channel, one transfer per allocated or listed
//   block, or a single transfer for a delete or an error; m_axis_tlast marks
//   the final result of each item. A mode-3 item gives no result.
//   Steps: after the idle state takes the item, a create does the space check,
//   then examines slots in order (up to FILE_SLOTS) and then blocks in order
//   (up to NUM_BLOCKS). Delete and list check the slot and read the count,
//   then take each chain entry with one chain memory read and one use,
//   and a delete ends with a separate step for its result. The block bitmap
//   walk and the single read port of the chain memory set this order.
//   The output register lets the next item be taken while the final result
//   still waits; when the receiver stalls, the create and list walks hold on the
//   pending result. Reset frees all blocks and slots at once; the chain and count
//   memories need no clearing pass.
// ============================================================================
module file_block_allocator #(
    parameter int NUM_BLOCKS  = 16,
    parameter int FILE_SLOTS  = 16,
    parameter int BLOCK_BYTES = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // mode[1:0], file_size[11:2], file_id[15:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[1:0], slot[5:2], block_index[9:6], 0
    output logic        m_axis_tlast
);
    import fba_pkg::*;

    fba_cmd_t              cmd;
    fba_sts_t              sts;
    logic [MODE_W-1:0]     in_mode;
    logic [SIZE_W-1:0]     in_file_size;
    logic [ID_W-1:0]       in_file_id;
    logic [STATUS_W-1:0]   out_status;
    logic [SLOT_O_W-1:0]   out_slot;
    logic [BLK_O_W-1:0]    out_block_index;

    // Unpack input fields
    assign in_mode      = s_axis_tdata[1:0];
    assign in_file_size = s_axis_tdata[11:2];
    assign in_file_id   = s_axis_tdata[15:12];

    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (in_mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    fba_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .FILE_SLOTS  (FILE_SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_mode         (in_mode),
        .in_file_size    (in_file_size),
        .in_file_id      (in_file_id),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_status      (out_status),
        .out_slot        (out_slot),
        .out_block_index (out_block_index),
        .out_last        (m_axis_tlast)
    );

    // Pack result fields
    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {6'd0, out_block_index, out_slot, out_status};

endmodule

[verif/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the file block allocator. Items go in on the input
// stream. A scoreboard keeps its own copy of the block bitmap, the slot table
// and the chains, works out the results of each accepted item, and checks
// every output transfer in order. Both sides idle at random.
// ============================================================================
module tb;

    import fba_pkg::*;

    localparam int NUM_BLOCKS  = 16;
    localparam int FILE_SLOTS  = 16;
    localparam int BLOCK_BYTES = 50;
    localparam int ITEM_COUNT  = 170;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 48;

    // Mode that the block drops without a result
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_O_W-1:0] slot;
        logic [BLK_O_W-1:0]  blk;
        logic                last;
    } alloc_result_t;

    // Shadow of the allocation table and the queue of results still owed
    class alloc_scoreboard;
        bit                 blk_taken [NUM_BLOCKS];
        bit                 slot_taken [FILE_SLOTS];
        int                 chain_len [FILE_SLOTS];
        logic [BLK_O_W-1:0] chain [FILE_SLOTS][NUM_BLOCKS];
        int                 n_free;
        alloc_result_t      owed [$];
        int                 errors;
        int                 n_items;
        int                 n_results;
        int                 status_seen [4];

        function new();
            n_free = NUM_BLOCKS;
        endfunction

        function void owe(logic [STATUS_W-1:0] status, int slot, int blk, bit last);
            alloc_result_t r;
            r.status = status;
            r.slot   = SLOT_O_W'(slot);
            r.blk    = BLK_O_W'(blk);
            r.last   = last;
            owed.push_back(r);
        endfunction

        // Apply one accepted item to the shadow table and queue its results
        function void take_request(logic [MODE_W-1:0] mode, logic [SIZE_W-1:0] size,
                                   logic [ID_W-1:0] id);
            int need;
            int s;
            int n;
            n_items++;
            case (mode)
                MODE_CREATE:
                begin
                    need = int'(size) / BLOCK_BYTES + ((int'(size) % BLOCK_BYTES) != 0);
                    if (need == 0)
                        need = 1;
                    if (need > n_free)
                    begin
                        owe(ST_NO_SPACE, 0, 0, 1'b1);
                        return;
                    end
                    s = 0;
                    while (s < FILE_SLOTS && slot_taken[s])
                        s++;
                    if (s == FILE_SLOTS)
                    begin
                        owe(ST_NO_SLOT, 0, 0, 1'b1);
                        return;
                    end
                    slot_taken[s] = 1'b1;
                    chain_len[s]  = need;
                    n_free        = n_free - need;
                    n             = 0;
                    // First fit: lowest free blocks, in ascending order
                    for (int b = 0; b < NUM_BLOCKS && n < need; b++)
                    begin
                        if (!blk_taken[b])
                        begin
                            blk_taken[b] = 1'b1;
                            chain[s][n]  = BLK_O_W'(b);
                            owe(ST_OK, s, b, n + 1 == need);
                            n++;
                        end
                    end
                end
                MODE_DELETE:
                begin
                    if (!slot_taken[id])
                    begin
                        owe(ST_NOT_IN_USE, id, 0, 1'b1);
                        return;
                    end
                    for (int j = 0; j < chain_len[id]; j++)
                    begin
                        blk_taken[chain[id][j]] = 1'b0;
                        n_free++;
                    end
                    slot_taken[id] = 1'b0;
                    owe(ST_OK, id, 0, 1'b1);
                end
                MODE_LIST:
                begin
                    if (!slot_taken[id])
                    begin
                        owe(ST_NOT_IN_USE, id, 0, 1'b1);
                        return;
                    end
                    for (int j = 0; j < chain_len[id]; j++)
                        owe(ST_OK, id, chain[id][j], j + 1 == chain_len[id]);
                end
                default:
                begin
                    // ignored mode: no result, no change
                end
            endcase
        endfunction

        // Compare one output transfer with the oldest owed result
        function void match_result(logic [STATUS_W-1:0] status, logic [SLOT_O_W-1:0] slot,
                                   logic [BLK_O_W-1:0] blk, logic last);
            alloc_result_t e;
            n_results++;
            status_seen[status]++;
            if (owed.size() == 0)
            begin
                $error("result with nothing owed: status %0d slot %0d block_index %0d last %0d",
                       status, slot, blk, last);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (slot !== e.slot)
            begin
                $error("slot: expected %0d, got %0d", e.slot, slot);
                errors++;
            end
            if (blk !== e.blk)
            begin
                $error("block_index: expected %0d, got %0d", e.blk, blk);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // mode[1:0], file_size[11:2], file_id[15:12]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // status[1:0], slot[5:2], block_index[9:6], 0
    logic        m_axis_tlast;

    alloc_scoreboard sb = new();
    bit              calm = 1'b0;
    int              quiet_cycles = 0;

    file_block_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .FILE_SLOTS  (FILE_SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock: period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result stream at random, except in the calm stretch
    always @(negedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 25);
    end

    // Sample transfers on both streams and watch for a hang
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.take_request(s_axis_tdata[1:0], s_axis_tdata[11:2], s_axis_tdata[15:12]);
        if (m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[9:6],
                            m_axis_tlast);
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Offer one item, idling at random first; return at the next falling edge
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                             input logic [ID_W-1:0] id);
        while (!calm && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {id, size, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Hold the input until every owed result has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.owed.size() != 0);
    endtask

    // Pick a slot in use most of the time, else any slot
    function automatic logic [ID_W-1:0] pick_slot();
        int taken [$];
        for (int s = 0; s < FILE_SLOTS; s++)
            if (sb.slot_taken[s])
                taken.push_back(s);
        if (taken.size() == 0 || $urandom_range(99) < 15)
            return ID_W'($urandom_range(FILE_SLOTS - 1));
        return ID_W'(taken[$urandom_range(taken.size() - 1)]);
    endfunction

    initial
    begin
        int                sent;
        int                pick;
        logic [SIZE_W-1:0] size;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: free-slot errors, zero size, boundaries, split chains, full pool
        send_item(MODE_LIST,    0,    0);
        send_item(MODE_DELETE,  0,    15);
        send_item(MODE_CREATE,  0,    0);
        send_item(MODE_CREATE,  1,    7);
        send_item(MODE_CREATE,  50,   0);
        send_item(MODE_CREATE,  51,   0);
        send_item(MODE_CREATE,  1023, 0);
        send_item(MODE_LIST,    0,    3);
        send_item(MODE_DELETE,  0,    1);
        send_item(MODE_CREATE,  100,  0);
        send_item(MODE_DELETE,  0,    1);
        send_item(MODE_DELETE,  0,    1);
        send_item(MODE_IGNORED, 1023, 15);
        send_item(MODE_CREATE,  800,  0);
        send_item(MODE_CREATE,  600,  0);
        send_item(MODE_CREATE,  0,    0);
        send_item(MODE_LIST,    0,    1);
        hold_until_drained();
        send_item(MODE_DELETE,  0,    0);
        send_item(MODE_DELETE,  0,    1);
        send_item(MODE_DELETE,  0,    2);
        send_item(MODE_DELETE,  0,    3);
        send_item(MODE_CREATE,  800,  0);
        send_item(MODE_LIST,    0,    0);
        send_item(MODE_DELETE,  0,    0);

        // Random: mostly creates and operations on live slots
        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            calm = (sent >= 80 && sent < 130);
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                case ($urandom_range(19))
                    0:       size = 0;
                    1, 2, 3: size = SIZE_W'($urandom_range(301, SIZE_MAX));
                    4:       size = SIZE_W'($urandom_range(SIZE_MAX));
                    default: size = SIZE_W'($urandom_range(1, 300));
                endcase
                send_item(MODE_CREATE, size, ID_W'($urandom_range(FILE_SLOTS - 1)));
            end
            else if (pick < 70)
                send_item(MODE_DELETE, SIZE_W'($urandom_range(SIZE_MAX)), pick_slot());
            else if (pick < 95)
                send_item(MODE_LIST, SIZE_W'($urandom_range(SIZE_MAX)), pick_slot());
            else
                send_item(MODE_IGNORED, SIZE_W'($urandom_range(SIZE_MAX)),
                          ID_W'($urandom_range(FILE_SLOTS - 1)));
            if (pick < 95)
                sent++;
            if (sent % 50 == 49)
                hold_until_drained();
        end
        calm = 1'b0;

        // Drain, then give the block time for any stray output
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items, %0d results: %0d ok, %0d no space, %0d no slot, %0d unused",
                 sb.n_items, sb.n_results, sb.status_seen[ST_OK], sb.status_seen[ST_NO_SPACE],
                 sb.status_seen[ST_NO_SLOT], sb.status_seen[ST_NOT_IN_USE]);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
